FILE: rtl/line_follow_pid_drive_defines.svh
// Assertion helpers for the RTL (used by lfpd_ctrl).
`ifndef LINE_FOLLOW_PID_DRIVE_DEFINES_SVH
`define LINE_FOLLOW_PID_DRIVE_DEFINES_SVH

// Implication checked on every rising clock edge, not while in reset.
`define LFPD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge, not while in reset.
`define LFPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/lfpd_pkg.sv
`default_nettype none
package lfpd_pkg;
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_SEC    = 2'd1;
   localparam logic [1:0] CMD_TENTH  = 2'd2;

   localparam logic [2:0] PH_WAIT = 3'd0;
   localparam logic [2:0] PH_HOLD = 3'd1;
   localparam logic [2:0] PH_OVER = 3'd2;
   localparam logic [2:0] PH_FIND = 3'd3;
   localparam logic [2:0] PH_TURN = 3'd4;
   localparam logic [2:0] PH_NAV  = 3'd5;

   localparam logic [2:0] DRV_NONE  = 3'd0;
   localparam logic [2:0] DRV_STOP  = 3'd1;
   localparam logic [2:0] DRV_FWD   = 3'd2;
   localparam logic [2:0] DRV_SRGT  = 3'd3;
   localparam logic [2:0] DRV_SLFT  = 3'd4;
   localparam logic [2:0] DRV_MLFT  = 3'd5;
   localparam logic [2:0] DRV_MRGT  = 3'd6;
   localparam logic [2:0] DRV_SPEED = 3'd7;

   localparam logic [2:0] REG_WHITE_L = 3'd0;
   localparam logic [2:0] REG_WHITE_R = 3'd1;
   localparam logic [2:0] REG_BLACK_L = 3'd2;
   localparam logic [2:0] REG_BLACK_R = 3'd3;
   localparam logic [2:0] REG_CRUISE  = 3'd4;
   localparam logic [2:0] REG_PERIOD  = 3'd5;
   localparam logic [2:0] REG_CAP     = 3'd6;
   localparam logic [2:0] REG_GAIN    = 3'd7;

   localparam logic [16:0] KP_Q8 = 17'd46925;
   localparam logic [16:0] KD_Q8 = 17'd26189;
   localparam logic [16:0] KI_Q8 = 17'd5;
   localparam int SumLimit  = 1000;
   localparam int CorrLimit = 15000;
   localparam int MinSpeed  = 5000;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture readings, start PID
      logic mul_p;
      logic mul_d;
      logic mul_i;
      logic scale;
      logic finish;   // form speeds
   } dp_cmd_type;

   typedef struct packed {
      logic white_seen;
      logic turn_side;
   } dp_stat_type;
endpackage
`default_nettype wire

FILE: rtl/lfpd_if.sv
`default_nettype none
interface lfpd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [9:0] left_reading;
   logic [9:0] right_reading;
   modport source (output valid, cmd, left_reading, right_reading, input ready);
   modport sink (input valid, cmd, left_reading, right_reading, output ready);
endinterface

interface lfpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  drive_mode;
   logic [15:0] left_speed;
   logic [15:0] right_speed;
   logic [2:0]  phase;
   modport source (output valid, drive_mode, left_speed, right_speed, phase, input ready);
   modport sink (input valid, drive_mode, left_speed, right_speed, phase, output ready);
endinterface

interface lfpd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lfpd_datapath.sv
`default_nettype none
module lfpd_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lfpd_pkg::dp_cmd_type cmd,
   input  wire logic [9:0]           left_in,
   input  wire logic [9:0]           right_in,
   input  wire logic [9:0]           white_left,
   input  wire logic [9:0]           white_right,
   input  wire logic [15:0]          cruise_speed,
   input  wire logic [15:0]          speed_limit,
   input  wire logic [15:0]          cap_speed,
   input  wire logic [15:0]          gain_scale,
   output lfpd_pkg::dp_stat_type     stat,
   output logic [15:0]               left_speed,
   output logic [15:0]               right_speed
);
   logic signed [10:0] last_error_ff, last_error_in;
   logic signed [10:0] error_sum_ff, error_sum_in;
   logic               turn_side_ff, turn_side_in;
   logic signed [10:0] p_ff;
   logic signed [11:0] d_ff;
   logic               white_ff;
   logic signed [35:0] acc_ff, acc_in;
   logic [13:0]        qcorr_ff;
   logic               neg_ff;

   logic signed [11:0] p_w, d_w, sum_w;
   logic signed [17:0] mul_a;
   logic signed [28:0] prod;
   logic [35:0]        mag;
   logic [51:0]        scaled;
   logic [35:0]        q;
   logic signed [17:0] corr, rsp, lsp, rcap, lcap;

   always_comb begin
      p_w = 12'(signed'({2'b00, right_in})) - 12'(signed'({2'b00, left_in}));
      d_w = p_w - 12'(last_error_ff);
      sum_w = 12'(error_sum_ff) + p_w;
      if (sum_w > 12'sd1000) sum_w = 12'sd1000;
      else if (sum_w < -12'sd1000) sum_w = -12'sd1000;

      // one shared multiplier: p, d, then integral
      if (cmd.mul_p) mul_a = 18'(p_ff);
      else if (cmd.mul_d) mul_a = 18'(d_ff);
      else mul_a = 18'(error_sum_ff);
      if (cmd.mul_p) prod = 29'(mul_a) * 29'(signed'({1'b0, lfpd_pkg::KP_Q8}));
      else if (cmd.mul_d) prod = 29'(mul_a) * 29'(signed'({1'b0, lfpd_pkg::KD_Q8}));
      else prod = 29'(mul_a) * 29'(signed'({1'b0, lfpd_pkg::KI_Q8}));

      acc_in = acc_ff;
      if (cmd.mul_p) acc_in = 36'(prod);
      else if (cmd.mul_d || cmd.mul_i) acc_in = acc_ff + 36'(prod);

      mag = acc_ff[35] ? 36'(-acc_ff) : 36'(acc_ff);
      scaled = 52'(mag[27:0]) * 52'(gain_scale);
      q = 36'(scaled >> 16);

      corr = neg_ff ? -18'(signed'({4'b0, qcorr_ff})) : 18'(signed'({4'b0, qcorr_ff}));
      rsp = 18'(signed'({2'b0, cruise_speed})) - corr;
      lsp = 18'(signed'({2'b0, cruise_speed})) + corr;
      rcap = (rsp > 18'(signed'({2'b0, speed_limit}))) ?
             18'(signed'({2'b0, cap_speed})) : rsp;
      lcap = (lsp > 18'(signed'({2'b0, speed_limit}))) ?
             18'(signed'({2'b0, cap_speed})) : lsp;
      if (rcap < 18'sd5000) rcap = 18'sd5000;
      if (lcap < 18'sd5000) lcap = 18'sd5000;

      last_error_in = last_error_ff;
      error_sum_in = error_sum_ff;
      turn_side_in = turn_side_ff;
      if (cmd.load) begin
         last_error_in = 11'(p_w);
         error_sum_in = 11'(sum_w);
      end
      if (cmd.finish) turn_side_in = !neg_ff || qcorr_ff == 14'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff <= '0;
         turn_side_ff <= 1'b1;
      end else begin
         last_error_ff <= last_error_in;
         error_sum_ff <= error_sum_in;
         turn_side_ff <= turn_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff <= 11'(p_w);
         d_ff <= d_w;
         white_ff <= (17'(right_in) * 17'd100 <= 17'(white_right) * 17'd101) &&
                     (17'(left_in) * 17'd100 <= 17'(white_left) * 17'd101);
      end
      acc_ff <= acc_in;
      if (cmd.scale) begin
         neg_ff <= acc_ff[35];
         qcorr_ff <= (q > 36'(lfpd_pkg::CorrLimit)) ? 14'(lfpd_pkg::CorrLimit) : q[13:0];
      end
      if (cmd.finish) begin
         left_speed <= lcap[15:0];
         right_speed <= rcap[15:0];
      end
   end

   assign stat.white_seen = white_ff;
   assign stat.turn_side = turn_side_in;
endmodule
`default_nettype wire

FILE: rtl/lfpd_ctrl.sv
`default_nettype none
`include "line_follow_pid_drive_defines.svh"
module lfpd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lfpd_req_if.sink                   req,
   lfpd_rsp_if.source                 rsp,
   input  wire logic [9:0]            black_left,
   input  wire logic [9:0]            black_right,
   input  wire lfpd_pkg::dp_stat_type stat,
   input  wire logic [15:0]           dp_left,
   input  wire logic [15:0]           dp_right,
   output lfpd_pkg::dp_cmd_type       cmd
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MULP  = 7'b0000010,
      ST_MULD  = 7'b0000100,
      ST_MULI  = 7'b0001000,
      ST_SCALE = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  phase_ff, phase_in, ret_ff, ret_in;
   logic [2:0]  sec_ff, sec_in, tenth_ff, tenth_in;
   logic [3:0]  lap_ff, lap_in;
   logic [1:0]  tick_ff, tick_in;
   logic [2:0]  flags_ff, flags_in;
   logic        rv_ff, rv_in, pid_ff, pid_in;
   logic [2:0]  drv_ff, drv_in;
   logic [15:0] ls_ff, rs_ff;
   logic        acc;
   logic [2:0]  fl;
   logic [1:0]  tk;

   assign req.ready = (state_ff == ST_IDLE) && !rv_ff;
   assign acc = req.valid && req.ready;
   assign rsp.valid = rv_ff;
   assign rsp.drive_mode = drv_ff;
   assign rsp.left_speed = ls_ff;
   assign rsp.right_speed = rs_ff;
   assign rsp.phase = phase_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff; ret_in = ret_ff; sec_in = sec_ff; tenth_in = tenth_ff;
      lap_in = lap_ff; tick_in = tick_ff; flags_in = flags_ff;
      rv_in = rv_ff; pid_in = pid_ff; drv_in = drv_ff;
      cmd = '0;
      fl = flags_ff;
      tk = tick_ff;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req.cmd == lfpd_pkg::CMD_SAMPLE) begin
                  fl[0] = req.right_reading >= 10'd730 || req.left_reading >= 10'd780;
                  fl[1] = req.right_reading >= black_right && req.left_reading >= black_left;
                  fl[2] = req.right_reading < 10'd905 && req.left_reading >= 10'd900;
               end else if (req.cmd == lfpd_pkg::CMD_SEC) tk[0] = 1'b1;
               else if (req.cmd == lfpd_pkg::CMD_TENTH) tk[1] = 1'b1;
               drv_in = lfpd_pkg::DRV_NONE;
               pid_in = 1'b0;
               case (phase_ff)
                  lfpd_pkg::PH_WAIT: if (tk[0]) begin
                     tk[0] = 1'b0;
                     drv_in = lfpd_pkg::DRV_STOP;
                     if (sec_ff == 3'd2) begin phase_in = ret_ff; sec_in = '0; end
                     else sec_in = sec_ff + 3'd1;
                  end
                  lfpd_pkg::PH_HOLD: if (tk[0]) begin
                     tk[0] = 1'b0;
                     if (sec_ff == 3'd6) begin phase_in = ret_ff; sec_in = '0; end
                     else sec_in = sec_ff + 3'd1;
                  end
                  lfpd_pkg::PH_OVER: if (tk[1]) begin
                     tk[1] = 1'b0;
                     if (tenth_ff == 3'd5) begin
                        drv_in = lfpd_pkg::DRV_STOP;
                        phase_in = lfpd_pkg::PH_WAIT;
                        tenth_in = '0;
                     end else tenth_in = tenth_ff + 3'd1;
                  end
                  lfpd_pkg::PH_FIND: begin
                     drv_in = lfpd_pkg::DRV_FWD;
                     if (fl[0]) begin
                        phase_in = lfpd_pkg::PH_OVER;
                        ret_in = lfpd_pkg::PH_TURN;
                     end
                  end
                  lfpd_pkg::PH_TURN: begin
                     if (fl[1]) begin
                        fl[1] = 1'b0; fl[2] = 1'b0;
                        drv_in = lfpd_pkg::DRV_STOP;
                        phase_in = lfpd_pkg::PH_HOLD;
                        ret_in = lfpd_pkg::PH_NAV;
                     end else if (fl[2]) begin
                        fl[2] = 1'b0;
                        drv_in = lfpd_pkg::DRV_SLFT;
                     end else drv_in = lfpd_pkg::DRV_SRGT;
                  end
                  lfpd_pkg::PH_NAV: if (req.cmd == lfpd_pkg::CMD_SAMPLE) begin
                     if (tk[0]) begin
                        tk[0] = 1'b0;
                        if (lap_ff == 4'd14) begin
                           lap_in = '0;
                           phase_in = lfpd_pkg::PH_WAIT;
                           ret_in = lfpd_pkg::PH_NAV;
                        end else lap_in = lap_ff + 4'd1;
                     end
                     pid_in = 1'b1;
                  end
                  default: ;
               endcase
               flags_in = fl;
               tick_in = tk;
               if (pid_in) begin
                  cmd.load = 1'b1;
                  state_in = ST_MULP;
               end else state_in = ST_OUT;
            end
         end
         ST_MULP: begin cmd.mul_p = 1'b1; state_in = ST_MULD; end
         ST_MULD: begin cmd.mul_d = 1'b1; state_in = ST_MULI; end
         ST_MULI: begin cmd.mul_i = 1'b1; state_in = ST_SCALE; end
         ST_SCALE: begin cmd.scale = 1'b1; state_in = ST_FIN; end
         ST_FIN: begin
            cmd.finish = 1'b1;
            if (stat.white_seen)
               drv_in = stat.turn_side ? lfpd_pkg::DRV_MLFT : lfpd_pkg::DRV_MRGT;
            else drv_in = lfpd_pkg::DRV_SPEED;
            state_in = ST_OUT;
         end
         ST_OUT: begin rv_in = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= lfpd_pkg::PH_WAIT;
         ret_ff <= lfpd_pkg::PH_FIND;
         sec_ff <= '0; tenth_ff <= '0; lap_ff <= '0; tick_ff <= '0; flags_ff <= '0;
         rv_ff <= 1'b0; pid_ff <= 1'b0; drv_ff <= lfpd_pkg::DRV_NONE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in; ret_ff <= ret_in; sec_ff <= sec_in; tenth_ff <= tenth_in;
         lap_ff <= lap_in; tick_ff <= tick_in; flags_ff <= flags_in;
         rv_ff <= rv_in; pid_ff <= pid_in; drv_ff <= drv_in;
      end
   end

   // speeds read zero unless the item's drive mode is DRV_SPEED
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT) begin
         ls_ff <= (drv_ff == lfpd_pkg::DRV_SPEED) ? dp_left : 16'd0;
         rs_ff <= (drv_ff == lfpd_pkg::DRV_SPEED) ? dp_right : 16'd0;
      end
   end

   `LFPD_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `LFPD_ASSERT_NEXT(a_pid_seq, clock, reset, state_ff == ST_MULP, state_ff == ST_MULD)
   `LFPD_ASSERT_IMP(a_busy, clock, reset, state_ff != ST_IDLE, !req.ready)
   `LFPD_ASSERT_IMP(a_phase_ok, clock, reset, 1'b1, phase_ff <= lfpd_pkg::PH_NAV)
endmodule
`default_nettype wire

FILE: rtl/line_follow_pid_drive.sv
// channel | dir | payload
// req_ch  | in  | cmd, left_reading, right_reading
// rsp_ch  | out | drive_mode, left_speed, right_speed, phase
// csr_ch  | in  | index, data
// A navigate sample: rsp valid rises after the states MULP, MULD, MULI (one shared
// multiplier: three passes), SCALE, FIN and OUT; any other item: after OUT only.
// One item in flight: the next req is taken the cycle after the rsp transfer.
// Reset is synchronous; registers with a reset value take it at the next clock edge.
// rsp_ch stalls hold the result and keep req_ch ready low.
`default_nettype none
module line_follow_pid_drive (
   input wire logic   clock,
   input wire logic   reset,
   lfpd_req_if.sink   req_ch,
   lfpd_rsp_if.source rsp_ch,
   lfpd_csr_if.sink   csr_ch
);
   logic [9:0]  wl_ff, wr_ff, bl_ff, br_ff;
   logic [15:0] cruise_ff, period_ff, cap_ff, gain_ff;
   lfpd_pkg::dp_cmd_type  cmd;
   lfpd_pkg::dp_stat_type stat;
   logic [15:0] dl, dr;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= '0; wr_ff <= '0; bl_ff <= 10'd1023; br_ff <= 10'd1023;
         cruise_ff <= 16'd20000; period_ff <= 16'd50000; cap_ff <= 16'd40000;
         gain_ff <= 16'd256;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            lfpd_pkg::REG_WHITE_L: wl_ff <= csr_ch.data[9:0];
            lfpd_pkg::REG_WHITE_R: wr_ff <= csr_ch.data[9:0];
            lfpd_pkg::REG_BLACK_L: bl_ff <= csr_ch.data[9:0];
            lfpd_pkg::REG_BLACK_R: br_ff <= csr_ch.data[9:0];
            lfpd_pkg::REG_CRUISE:  cruise_ff <= csr_ch.data;
            lfpd_pkg::REG_PERIOD:  period_ff <= csr_ch.data;
            lfpd_pkg::REG_CAP:     cap_ff <= csr_ch.data;
            lfpd_pkg::REG_GAIN:    gain_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   lfpd_datapath u_dp (
      .clock, .reset, .cmd,
      .left_in(req_ch.left_reading), .right_in(req_ch.right_reading),
      .white_left(wl_ff), .white_right(wr_ff), .cruise_speed(cruise_ff),
      .speed_limit(period_ff), .cap_speed(cap_ff), .gain_scale(gain_ff),
      .stat, .left_speed(dl), .right_speed(dr)
   );

   lfpd_ctrl u_ctrl (
      .clock, .reset, .req(req_ch), .rsp(rsp_ch), .black_left(bl_ff), .black_right(br_ff),
      .stat, .dp_left(dl), .dp_right(dr), .cmd
   );
endmodule
`default_nettype wire

FILE: tb/line_follow_pid_drive_test.sv
`default_nettype none
module line_follow_pid_drive_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 600000;
   localparam logic [1:0] CmdUnused = 2'd3;

   typedef struct packed {
      logic [2:0]  drive_mode;
      logic [15:0] left_speed;
      logic [15:0] right_speed;
      logic [2:0]  phase;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfpd_req_if req_if ();
   lfpd_rsp_if rsp_if ();
   lfpd_csr_if csr_if ();

   line_follow_pid_drive u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source),
      .csr_ch (csr_if.sink)
   );

   // predictor copy of the configuration
   logic [9:0]  cfg_white_l, cfg_white_r, cfg_black_l, cfg_black_r;
   logic [15:0] cfg_cruise, cfg_period, cfg_cap, cfg_gain;
   // predictor copy of the controller state
   logic [2:0]  ph, ret_ph;
   int unsigned sec_cnt, tenth_cnt, lap_cnt;
   logic        sec_pend, tenth_pend;
   logic        fl_inter, fl_full, fl_left;
   int          prev_err, err_sum;
   logic        side_left;

   drive_result_type expected_drives[$];
   int unsigned   cycle_count = 0;
   int unsigned   mismatches = 0;
   int unsigned   checked = 0;
   int unsigned   nav_samples = 0;
   bit            idling = 1'b1;
   int unsigned   rsp_holdoff = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_drives.size());
         $display("line_follow_pid_drive test failed");
         $finish;
      end
   end

   function automatic void reset_model();
      cfg_white_l = '0; cfg_white_r = '0; cfg_black_l = 10'd1023; cfg_black_r = 10'd1023;
      cfg_cruise = 16'd20000; cfg_period = 16'd50000; cfg_cap = 16'd40000;
      cfg_gain = 16'd256;
      ph = lfpd_pkg::PH_WAIT; ret_ph = lfpd_pkg::PH_FIND;
      sec_cnt = 0; tenth_cnt = 0; lap_cnt = 0;
      sec_pend = 0; tenth_pend = 0;
      fl_inter = 0; fl_full = 0; fl_left = 0;
      prev_err = 0; err_sum = 0; side_left = 1;
   endfunction

   function automatic void steer_step(input int lv, input int rv,
                                      output drive_result_type res);
      int     p, d, corr, rsp_v, lsp_v;
      longint s, mag, q;
      res = '0;
      p = rv - lv;
      d = p - prev_err;
      prev_err = p;
      err_sum += p;
      if (err_sum > lfpd_pkg::SumLimit) err_sum = lfpd_pkg::SumLimit;
      if (err_sum < -lfpd_pkg::SumLimit) err_sum = -lfpd_pkg::SumLimit;
      s = 64'(46925) * p + 64'(26189) * d + 64'(5) * err_sum;
      mag = (s < 0) ? -s : s;
      q = (mag * longint'(cfg_gain)) >>> 16;
      if (q > lfpd_pkg::CorrLimit) q = lfpd_pkg::CorrLimit;
      corr = (s < 0) ? -int'(q) : int'(q);
      side_left = (corr >= 0);
      rsp_v = int'(cfg_cruise) - corr;
      lsp_v = int'(cfg_cruise) + corr;
      if (rsp_v > int'(cfg_period)) rsp_v = int'(cfg_cap);
      if (lsp_v > int'(cfg_period)) lsp_v = int'(cfg_cap);
      if (rsp_v < lfpd_pkg::MinSpeed) rsp_v = lfpd_pkg::MinSpeed;
      if (lsp_v < lfpd_pkg::MinSpeed) lsp_v = lfpd_pkg::MinSpeed;
      if (rv * 100 <= int'(cfg_white_r) * 101 && lv * 100 <= int'(cfg_white_l) * 101) begin
         res.drive_mode = side_left ? lfpd_pkg::DRV_MLFT : lfpd_pkg::DRV_MRGT;
      end else begin
         res.drive_mode = lfpd_pkg::DRV_SPEED;
         res.left_speed = lsp_v[15:0];
         res.right_speed = rsp_v[15:0];
      end
   endfunction

   function automatic drive_result_type predict_drive(input logic [1:0] cmd,
                                                      input logic [9:0] lr,
                                                      input logic [9:0] rr);
      drive_result_type res;
      int lv, rv;
      res = '0;
      lv = int'(lr);
      rv = int'(rr);
      if (cmd == lfpd_pkg::CMD_SAMPLE) begin
         fl_inter = (rv >= 730 || lv >= 780);
         fl_full = (rr >= cfg_black_r && lr >= cfg_black_l);
         fl_left = (rv < 905 && lv >= 900);
      end else if (cmd == lfpd_pkg::CMD_SEC) begin
         sec_pend = 1;
      end else if (cmd == lfpd_pkg::CMD_TENTH) begin
         tenth_pend = 1;
      end
      case (ph)
         lfpd_pkg::PH_WAIT: begin
            if (sec_pend) begin
               sec_pend = 0;
               res.drive_mode = lfpd_pkg::DRV_STOP;
               sec_cnt++;
               if (sec_cnt >= 3) begin
                  ph = ret_ph;
                  sec_cnt = 0;
               end
            end
         end
         lfpd_pkg::PH_HOLD: begin
            if (sec_pend) begin
               sec_pend = 0;
               sec_cnt++;
               if (sec_cnt >= 7) begin
                  ph = ret_ph;
                  sec_cnt = 0;
               end
            end
         end
         lfpd_pkg::PH_OVER: begin
            if (tenth_pend) begin
               tenth_pend = 0;
               tenth_cnt++;
               if (tenth_cnt >= 6) begin
                  res.drive_mode = lfpd_pkg::DRV_STOP;
                  ph = lfpd_pkg::PH_WAIT;
                  tenth_cnt = 0;
               end
            end
         end
         lfpd_pkg::PH_FIND: begin
            res.drive_mode = lfpd_pkg::DRV_FWD;
            if (fl_inter) begin
               ph = lfpd_pkg::PH_OVER;
               ret_ph = lfpd_pkg::PH_TURN;
            end
         end
         lfpd_pkg::PH_TURN: begin
            if (fl_full) begin
               fl_full = 0;
               fl_left = 0;
               res.drive_mode = lfpd_pkg::DRV_STOP;
               ph = lfpd_pkg::PH_HOLD;
               ret_ph = lfpd_pkg::PH_NAV;
            end else if (fl_left) begin
               fl_left = 0;
               res.drive_mode = lfpd_pkg::DRV_SLFT;
            end else begin
               res.drive_mode = lfpd_pkg::DRV_SRGT;
            end
         end
         lfpd_pkg::PH_NAV: begin
            if (cmd == lfpd_pkg::CMD_SAMPLE) begin
               nav_samples++;
               if (sec_pend) begin
                  sec_pend = 0;
                  lap_cnt++;
                  if (lap_cnt >= 15) begin
                     lap_cnt = 0;
                     ph = lfpd_pkg::PH_WAIT;
                     ret_ph = lfpd_pkg::PH_NAV;
                  end
               end
               steer_step(lv, rv, res);
            end
         end
         default: ;
      endcase
      res.phase = ph;
      return res;
   endfunction

   // result checker: compares every rsp transfer against the oldest expectation
   always @(posedge clock) begin
      drive_result_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.drive_mode, rsp_if.left_speed, rsp_if.right_speed, rsp_if.phase};
         if (expected_drives.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: mode %0d L %0d R %0d phase %0d",
                        got.drive_mode, got.left_speed, got.right_speed, got.phase);
         end else begin
            want = expected_drives.pop_front();
            checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result %0d: expected mode %0d L %0d R %0d phase %0d, ",
                            "got mode %0d L %0d R %0d phase %0d"},
                           checked, want.drive_mode, want.left_speed, want.right_speed,
                           want.phase, got.drive_mode, got.left_speed, got.right_speed,
                           got.phase);
            end
         end
      end
   end

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin
      int unsigned burst;
      burst = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff > 0) begin
            rsp_holdoff--;
            rsp_if.ready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_if.ready <= 1'b0;
         end else if (idling && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 14) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // called at a falling edge; leaves valid high on return
   task automatic send_item(input logic [1:0] cmd, input logic [9:0] lr, input logic [9:0] rr);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.left_reading <= lr;
      req_if.right_reading <= rr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_drives.push_back(predict_drive(cmd, lr, rr));
      @(negedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_drives.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         lfpd_pkg::REG_WHITE_L: cfg_white_l = val[9:0];
         lfpd_pkg::REG_WHITE_R: cfg_white_r = val[9:0];
         lfpd_pkg::REG_BLACK_L: cfg_black_l = val[9:0];
         lfpd_pkg::REG_BLACK_R: cfg_black_r = val[9:0];
         lfpd_pkg::REG_CRUISE:  cfg_cruise = val;
         lfpd_pkg::REG_PERIOD:  cfg_period = val;
         lfpd_pkg::REG_CAP:     cfg_cap = val;
         lfpd_pkg::REG_GAIN:    cfg_gain = val;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [9:0] wl, input logic [9:0] wr,
                                input logic [9:0] bl, input logic [9:0] br,
                                input logic [15:0] cruise, input logic [15:0] period,
                                input logic [15:0] cap, input logic [15:0] gain);
      settle();
      write_reg(lfpd_pkg::REG_WHITE_L, {6'd0, wl});
      write_reg(lfpd_pkg::REG_WHITE_R, {6'd0, wr});
      write_reg(lfpd_pkg::REG_BLACK_L, {6'd0, bl});
      write_reg(lfpd_pkg::REG_BLACK_R, {6'd0, br});
      write_reg(lfpd_pkg::REG_CRUISE, cruise);
      write_reg(lfpd_pkg::REG_PERIOD, period);
      write_reg(lfpd_pkg::REG_CAP, cap);
      write_reg(lfpd_pkg::REG_GAIN, gain);
   endtask

   // picks an item that moves the current phase along most of the time
   task automatic route_step();
      int unsigned r;
      logic [9:0] lv, rv;
      r = $urandom_range(0, 99);
      lv = 10'($urandom_range(0, 1023));
      rv = 10'($urandom_range(0, 1023));
      if (r >= 97) begin
         send_item(CmdUnused, lv, rv);
      end else begin
         case (ph)
            lfpd_pkg::PH_WAIT, lfpd_pkg::PH_HOLD:
               if (r < 70) send_item(lfpd_pkg::CMD_SEC, lv, rv);
               else if (r < 82) send_item(lfpd_pkg::CMD_TENTH, lv, rv);
               else send_item(lfpd_pkg::CMD_SAMPLE, lv, rv);
            lfpd_pkg::PH_OVER:
               if (r < 70) send_item(lfpd_pkg::CMD_TENTH, lv, rv);
               else if (r < 82) send_item(lfpd_pkg::CMD_SEC, lv, rv);
               else send_item(lfpd_pkg::CMD_SAMPLE, lv, rv);
            lfpd_pkg::PH_TURN:
               if (r < 30) send_item(lfpd_pkg::CMD_SAMPLE,
                                     10'($urandom_range(cfg_black_l, 1023)),
                                     10'($urandom_range(cfg_black_r, 1023)));
               else if (r < 60) send_item(lfpd_pkg::CMD_SAMPLE,
                                          10'($urandom_range(900, 1023)),
                                          10'($urandom_range(0, 904)));
               else send_item(r < 70 ? lfpd_pkg::CMD_SEC : lfpd_pkg::CMD_SAMPLE, lv, rv);
            lfpd_pkg::PH_NAV:
               if (r < 10) send_item(lfpd_pkg::CMD_SEC, lv, rv);
               else if (r < 13) send_item(lfpd_pkg::CMD_TENTH, lv, rv);
               else if (r < 20) send_item(lfpd_pkg::CMD_SAMPLE,
                                          10'($urandom_range(0, cfg_white_l)),
                                          10'($urandom_range(0, cfg_white_r)));
               else if (r < 60) begin
                  // small error keeps the correction inside its clamp
                  rv = 10'($urandom_range(lv < 40 ? 0 : lv - 40, lv > 983 ? 1023 : lv + 40));
                  send_item(lfpd_pkg::CMD_SAMPLE, lv, rv);
               end else send_item(lfpd_pkg::CMD_SAMPLE, lv, rv);
            default:
               send_item(lfpd_pkg::CMD_SAMPLE, lv, rv);
         endcase
      end
   endtask

   task automatic test_directed_course();
      send_item(CmdUnused, 10'd0, 10'd0);
      send_item(lfpd_pkg::CMD_TENTH, 10'd1023, 10'd1023);
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd1023, 10'd0);
      repeat (3) send_item(lfpd_pkg::CMD_SEC, 10'd0, 10'd0);
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd779, 10'd729);   // just short of intersect
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd0, 10'd730);     // intersect on the right edge
      send_item(lfpd_pkg::CMD_SEC, 10'd0, 10'd0);
      repeat (6) send_item(lfpd_pkg::CMD_TENTH, 10'd0, 10'd0);
      repeat (3) send_item(lfpd_pkg::CMD_SEC, 10'd0, 10'd0);
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd900, 10'd904);   // left turn
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd900, 10'd905);   // right turn
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd1023, 10'd1023); // full black
      repeat (7) send_item(lfpd_pkg::CMD_SEC, 10'd0, 10'd0);
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd0, 10'd1023);
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd1023, 10'd0);
      send_item(lfpd_pkg::CMD_SAMPLE, 10'd0, 10'd0);       // both white
   endtask

   task automatic test_random_route(input int unsigned n);
      repeat (n) route_step();
   endtask

   task automatic test_backpressure();
      settle();
      rsp_holdoff = 300;
      test_random_route(40);
      settle();
   endtask

   task automatic test_setting_sweep();
      load_settings(10'd1023, 10'd1023, 10'd0, 10'd0, 16'hffff, 16'd0, 16'd0, 16'hffff);
      test_random_route(150);
      load_settings(10'd0, 10'd0, 10'd1023, 10'd1023, 16'd0, 16'hffff, 16'hffff, 16'd0);
      test_random_route(150);
      repeat (2) begin
         load_settings(10'($urandom_range(0, 300)), 10'($urandom_range(0, 300)),
                       10'($urandom_range(700, 1023)), 10'($urandom_range(700, 1023)),
                       16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom_range(0, 2048)));
         test_random_route(150);
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.cmd = lfpd_pkg::CMD_SAMPLE;
      req_if.left_reading = '0;
      req_if.right_reading = '0;
      csr_if.valid = 1'b0;
      csr_if.index = lfpd_pkg::REG_WHITE_L;
      csr_if.data = '0;
      reset_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_course();
      test_random_route(230);
      test_backpressure();
      test_setting_sweep();
      load_settings(10'd200, 10'd200, 10'd1000, 10'd1000, 16'd20000, 16'd50000, 16'd40000,
                    16'd256);
      idling = 1'b0;
      test_random_route(150);
      settle();
      repeat (20) @(posedge clock);
      $display("checked %0d results, %0d of them PID steps in navigate, over six settings",
               checked, nav_samples);
      if (mismatches == 0) begin
         $display("line_follow_pid_drive test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("line_follow_pid_drive test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
